// ===== rtl/ole_pkg.sv =====
// Package for the ordered list engine: sizes, codes, payload and control types.
// Used by the channel interfaces, the entry store and the top level.
package ole_pkg;

	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int FUNC_W     = 3;
	localparam int VAL_W      = 32;
	localparam int POS_W      = 5;
	localparam int STAT_W     = 2;
	localparam int CMP_W      = (POS_W > CNT_W) ? POS_W : CNT_W;

	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [DATA_WIDTH-1:0] word_t;

	localparam cnt_t CAP_CNT = cnt_t'(CAPACITY);

	typedef enum logic [FUNC_W-1:0] {
		FN_APPEND     = 3'd0,
		FN_POP_HEAD   = 3'd1,
		FN_POP_TAIL   = 3'd2,
		FN_REMOVE_VAL = 3'd3,
		FN_REMOVE_POS = 3'd4,
		FN_SEARCH     = 3'd5
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_SCAN,
		SEQ_SHIFT,
		SEQ_RESP
	} seq_state_t;

	typedef struct packed {
		logic [FUNC_W-1:0]       func;
		logic signed [VAL_W-1:0] value;
		logic [POS_W-1:0]        position;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0]       status;
		logic signed [VAL_W-1:0] entry_value;
		logic [POS_W-1:0]        found_position;
		logic [POS_W-1:0]        entry_count;
	} rsp_t;

	// Sequencer to store.
	typedef struct packed {
		logic  rd_en;
		logic  rd_shift;
		idx_t  rd_addr;
		logic  wr_en;
		idx_t  wr_addr;
		word_t wr_data;
	} store_cmd_t;

	// Store to sequencer: registered read data with its tag.
	typedef struct packed {
		logic  valid;
		logic  shift;
		idx_t  idx;
		word_t data;
	} store_rsp_t;

endpackage

// ===== rtl/ole_if.sv =====
// Valid/ready channel interfaces for requests and responses.
// Depends on ole_pkg for the payload structs.
interface ole_req_if import ole_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface ole_rsp_if import ole_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/ole_store.sv =====
// Entry store: one write port, one registered read port with a tag.
// Depends on ole_pkg for the command and response structs.
module ole_store import ole_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  store_cmd_t cmd,
	output store_rsp_t rsp
);

	word_t mem [CAPACITY];
	word_t rd_data_q;
	logic  rd_valid_q;
	logic  rd_shift_q;
	idx_t  rd_idx_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[cmd.wr_addr] <= cmd.wr_data;
		end
		rd_data_q <= mem[cmd.rd_addr];
		rd_idx_q  <= cmd.rd_addr;
		rd_shift_q <= cmd.rd_shift;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= cmd.rd_en;
		end
	end

	assign rsp.valid = rd_valid_q;
	assign rsp.shift = rd_shift_q;
	assign rsp.idx   = rd_idx_q;
	assign rsp.data  = rd_data_q;

endmodule

// ===== rtl/ordered_list_engine.sv =====
// Ordered list engine top level: request decode, scan/shift sequencer, response register.
// Depends on ole_pkg, ole_if (channel interfaces) and ole_store (entry memory).

// Keeps up to CAPACITY signed values in arrival order in a memory with one write port and
// one registered read port. Append, any request that is rejected at decode (empty list,
// full list, position past the end) and an unused func code (answered ok, list unchanged)
// complete at decode: the result is loaded into the response register in the cycle the
// transaction is accepted. Search and the removals walk the memory through its one read
// port: the scan reads one entry per cycle starting at the target index (head, tail,
// position, or the head for a value match), and the result then passes through the
// response state. A removal first closes the gap by reading each later entry and writing
// it one slot down, one entry per cycle. Scan and shift together cover the list once.
// Requests are taken only while the sequencer is idle and the response register is free
// or being emptied in the same cycle. The memory is not cleared at reset; only entries
// below the count are ever read.
module ordered_list_engine import ole_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	ole_req_if.sink   req,
	ole_rsp_if.source rsp
);

	seq_state_t state_q, state_d;
	cnt_t       count_q, count_d;
	cnt_t       scan_q, scan_d;      // next index to read during a scan
	cnt_t       sh_q, sh_d;          // next source index during a shift
	word_t      key_q, key_d;
	logic       by_value_q, by_value_d;
	logic       remove_q, remove_d;
	rsp_t       pend_q, pend_d;      // result parked while a shift runs
	logic       rsp_valid_q, rsp_valid_d;
	rsp_t       rsp_data_q, rsp_data_d;

	store_cmd_t st_cmd;
	store_rsp_t st_rsp;

	logic       slot_free;
	logic       accept;
	word_t      in_word;
	logic [CMP_W-1:0] pos_idx;
	logic       scan_hit;
	cnt_t       hit_cnt;

	ole_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (st_cmd),
		.rsp    (st_rsp)
	);

	assign slot_free = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == SEQ_IDLE) && slot_free;
	assign accept    = req.valid && req.ready;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	// Incoming value sign-extended (or truncated) to the stored width.
	assign in_word = word_t'(DATA_WIDTH'(req.data.value));
	// Position 0 and 1 both address the head.
	assign pos_idx = (req.data.position == '0) ? '0
		: CMP_W'(req.data.position) - CMP_W'(1);

	assign hit_cnt  = cnt_t'(st_rsp.idx);
	assign scan_hit = by_value_q ? (st_rsp.data == key_q) : 1'b1;

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		scan_d      = scan_q;
		sh_d        = sh_q;
		key_d       = key_q;
		by_value_d  = by_value_q;
		remove_d    = remove_q;
		pend_d      = pend_q;
		rsp_data_d  = rsp_data_q;
		rsp_valid_d = rsp_valid_q && !rsp.ready;
		st_cmd      = '0;

		unique case (state_q)
			SEQ_IDLE: begin
				if (accept) begin
					rsp_valid_d                = 1'b1;
					rsp_data_d.status          = STAT_OK;
					rsp_data_d.entry_value     = '0;
					rsp_data_d.found_position  = '0;
					rsp_data_d.entry_count     = POS_W'(count_q);
					key_d      = in_word;
					by_value_d = 1'b0;
					remove_d   = 1'b1;
					scan_d     = '0;
					unique case (req.data.func)
						FN_APPEND: begin
							if (count_q >= CAP_CNT) begin
								rsp_data_d.status = STAT_FULL;
							end else begin
								st_cmd.wr_en   = 1'b1;
								st_cmd.wr_addr = count_q[IDX_W-1:0];
								st_cmd.wr_data = in_word;
								count_d        = count_q + cnt_t'(1);
								rsp_data_d.entry_count = POS_W'(count_q + cnt_t'(1));
							end
						end
						FN_POP_HEAD, FN_POP_TAIL, FN_REMOVE_VAL, FN_REMOVE_POS,
						FN_SEARCH: begin
							if (count_q == '0) begin
								rsp_data_d.status = STAT_EMPTY;
							end else if (req.data.func == FN_REMOVE_POS
								&& pos_idx >= CMP_W'(count_q)) begin
								rsp_data_d.status = STAT_NOT_FOUND;
							end else begin
								// Long operation: result comes from the scan.
								rsp_valid_d = 1'b0;
								state_d     = SEQ_SCAN;
								if (req.data.func == FN_POP_TAIL) begin
									scan_d = count_q - cnt_t'(1);
								end else if (req.data.func == FN_REMOVE_POS) begin
									scan_d = cnt_t'(pos_idx);
								end
								by_value_d = (req.data.func == FN_REMOVE_VAL)
									|| (req.data.func == FN_SEARCH);
								remove_d   = (req.data.func != FN_SEARCH);
							end
						end
						default: begin
							// unused codes: no change, plain ok
						end
					endcase
				end
			end

			SEQ_SCAN: begin
				st_cmd.rd_en   = (scan_q < count_q);
				st_cmd.rd_addr = scan_q[IDX_W-1:0];
				if (st_cmd.rd_en) begin
					scan_d = scan_q + cnt_t'(1);
				end
				if (st_rsp.valid && !st_rsp.shift) begin
					pend_d.entry_count = POS_W'(count_q);
					if (scan_hit) begin
						pend_d.status         = STAT_OK;
						pend_d.entry_value    = VAL_W'(st_rsp.data);
						pend_d.found_position = POS_W'(hit_cnt + cnt_t'(1));
						if (remove_q) begin
							pend_d.entry_count = POS_W'(count_q - cnt_t'(1));
							sh_d    = hit_cnt + cnt_t'(1);
							state_d = SEQ_SHIFT;
						end else begin
							state_d = SEQ_RESP;
						end
					end else if (hit_cnt == count_q - cnt_t'(1)) begin
						pend_d.status         = STAT_NOT_FOUND;
						pend_d.entry_value    = '0;
						pend_d.found_position = '0;
						state_d               = SEQ_RESP;
					end
				end
			end

			SEQ_SHIFT: begin
				// read entry j, write its registered read data to j-1
				st_cmd.rd_en    = (sh_q < count_q);
				st_cmd.rd_shift = 1'b1;
				st_cmd.rd_addr  = sh_q[IDX_W-1:0];
				if (st_cmd.rd_en) begin
					sh_d = sh_q + cnt_t'(1);
				end
				if (st_rsp.valid && st_rsp.shift) begin
					st_cmd.wr_en   = 1'b1;
					st_cmd.wr_addr = st_rsp.idx - idx_t'(1);
					st_cmd.wr_data = st_rsp.data;
				end else if (!st_cmd.rd_en) begin
					count_d = count_q - cnt_t'(1);
					state_d = SEQ_RESP;
				end
			end

			SEQ_RESP: begin
				if (slot_free) begin
					rsp_valid_d = 1'b1;
					rsp_data_d  = pend_q;
					state_d     = SEQ_IDLE;
				end
			end

			default: begin
				state_d = SEQ_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SEQ_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		scan_q     <= scan_d;
		sh_q       <= sh_d;
		key_q      <= key_d;
		by_value_q <= by_value_d;
		remove_q   <= remove_d;
		pend_q     <= pend_d;
		rsp_data_q <= rsp_data_d;
	end

	// Count never exceeds the list capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_CNT)
		else $error("entry count above capacity");

	// Reads only touch live entries.
	a_read_live: assert property (@(posedge clk) disable iff (!arst_n)
		st_cmd.rd_en |-> (cnt_t'(st_cmd.rd_addr) < count_q))
		else $error("read beyond last entry");

	// Count moves only on an accepted append or at the end of a shift.
	a_count_change: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> ($past(state_q == SEQ_SHIFT) || $past(accept)))
		else $error("count changed outside append or removal");

	// An empty-list status is only reported with an empty list.
	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.data.status == STAT_EMPTY) |-> (rsp.data.entry_count == '0))
		else $error("empty status with nonzero count");

endmodule

// ===== verif/ole_list_checker.sv =====
// List checker for the ordered list engine: tracks the list contents and compares responses.
// Depends on ole_pkg for the request/response structs and the func/status codes.
module ole_list_checker import ole_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req_data,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  rsp_t rsp_data,
	output int   fail_count,
	output int   expected_left,
	output int   checked_count,
	output int   rejected_count
);
	timeunit 1ns;
	timeprecision 1ps;

	// Current list, head at index 0.
	logic signed [VAL_W-1:0] shadow_list[$];
	// Responses owed by the block, oldest first.
	rsp_t                    owed_rsp_q[$];

	// Applies one request to the shadow list and returns the response it must produce.
	function automatic rsp_t apply_list_op(req_t op);
		rsp_t res;
		int   n;
		int   idx;
		res = '0;
		n = shadow_list.size();
		case (op.func)
			FN_APPEND: begin
				if (n >= CAPACITY)
					res.status = STAT_FULL;
				else
					shadow_list.push_back(op.value);
			end
			FN_POP_HEAD, FN_POP_TAIL, FN_REMOVE_VAL, FN_REMOVE_POS, FN_SEARCH: begin
				if (n == 0) begin
					res.status = STAT_EMPTY;
				end else begin
					case (op.func)
						FN_POP_HEAD:   idx = 0;
						FN_POP_TAIL:   idx = n - 1;
						FN_REMOVE_POS: idx = (op.position == 0) ? 0 : int'(op.position) - 1;
						default: begin
							// first match wins
							idx = n;
							for (int i = n - 1; i >= 0; i--)
								if (shadow_list[i] == op.value)
									idx = i;
						end
					endcase
					if (idx >= n) begin
						res.status = STAT_NOT_FOUND;
					end else begin
						res.found_position = POS_W'(idx + 1);
						res.entry_value    = shadow_list[idx];
						if (op.func != FN_SEARCH)
							shadow_list.delete(idx);
					end
				end
			end
			default: ; // spare codes: no change
		endcase
		res.entry_count = POS_W'(shadow_list.size());
		return res;
	endfunction

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			shadow_list.delete();
			owed_rsp_q.delete();
			fail_count     = 0;
			expected_left  = 0;
			checked_count  = 0;
			rejected_count = 0;
		end else begin
			// response side first: a request taken on this edge cannot answer on it
			if (rsp_valid && rsp_ready) begin
				if (owed_rsp_q.size() == 0) begin
					$display("%0t: response with nothing expected, actual status %0d value %0d",
						$time, rsp_data.status, rsp_data.entry_value);
					fail_count++;
				end else begin
					want = owed_rsp_q.pop_front();
					check_field("status", want.status, rsp_data.status);
					check_field("entry_value", want.entry_value, rsp_data.entry_value);
					check_field("found_position", want.found_position, rsp_data.found_position);
					check_field("entry_count", want.entry_count, rsp_data.entry_count);
					checked_count++;
					if (want.status != STAT_OK)
						rejected_count++;
				end
			end
			if (req_valid && req_ready)
				owed_rsp_q.push_back(apply_list_op(req_data));
			expected_left = owed_rsp_q.size();
		end
	end

endmodule

// ===== verif/tb_ordered_list_engine.sv =====
// Testbench top for the ordered list engine: clock, reset, request stimulus and verdict.
// Depends on ole_pkg, the ole_if channel interfaces, the RTL and ole_list_checker.
module tb_ordered_list_engine import ole_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	// Spare func codes; the block must answer them without touching the list.
	localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd6;
	localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd7;

	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

	localparam int RAND_PER_PHASE = 625;     // three throttling phases, ~1900 requests total
	localparam int POOL_N         = 6;       // small value pool so matches are common
	localparam int HOLD_CYCLES    = 400;     // long response backpressure window
	localparam int DRAIN_CYCLES   = 60;      // quiet window for stray responses after the drain
	localparam int CYCLE_LIMIT    = 600000;

	logic clk = 1'b0;
	logic arst_n;

	ole_req_if req_ch ();
	ole_rsp_if rsp_ch ();

	ordered_list_engine u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	int fail_total;
	int pending_rsp;
	int rsp_checked;
	int rsp_rejected;

	ole_list_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_ch.valid),
		.req_ready      (req_ch.ready),
		.req_data       (req_ch.data),
		.rsp_valid      (rsp_ch.valid),
		.rsp_ready      (rsp_ch.ready),
		.rsp_data       (rsp_ch.data),
		.fail_count     (fail_total),
		.expected_left  (pending_rsp),
		.checked_count  (rsp_checked),
		.rejected_count (rsp_rejected)
	);

	// 20 ns period
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Watchdog: a hung handshake ends the run here.
	int cycle_cnt;
	initial cycle_cnt = 0;
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses outstanding", cycle_cnt, pending_rsp);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Throttling knobs, percent of cycles spent idle on each side.
	int sender_idle_pct;
	int receiver_idle_pct;

	// Backpressure requests from the stimulus; the receiver serves them in its own process.
	int holds_asked;
	int holds_served;

	// Receiver: random ready, or a long forced stall when a hold-off is requested.
	// While ready is low the single response register stays full, so the block
	// must deassert req.ready and the sender sits on a pending transaction.
	initial begin
		int hold_left;
		rsp_ch.ready = 1'b0;
		holds_served = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (holds_served != holds_asked) begin
				hold_left = HOLD_CYCLES;
				holds_served++;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
			end
		end
	end

	// Offers one transaction at the falling edge and returns at the falling edge
	// after it was taken. Optional idle cycles come first, so valid is only ever
	// lowered and raised in different time steps.
	task automatic offer_request(input logic [FUNC_W-1:0] f, input logic signed [VAL_W-1:0] v,
			input logic [POS_W-1:0] p);
		req_t item;
		item.func     = f;
		item.value    = v;
		item.position = p;
		while ($urandom_range(99) < sender_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= item;
		// ready is sampled at the rising edge, before the block's registers update
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Random traffic is organized in episodes that either grow the list (mostly
	// appends, so full-list rejects happen) or shrink it (mostly removals, so the
	// empty case and the gap-closing shifts get exercised). Values come mostly from
	// a small per-episode pool, so value matches and duplicates are frequent.
	int                      episode_left;
	bit                      growing;
	logic signed [VAL_W-1:0] value_pool[POOL_N];

	task automatic issue_random_request();
		int                      roll;
		int                      append_pct;
		logic [FUNC_W-1:0]       f;
		logic signed [VAL_W-1:0] v;
		if (episode_left == 0) begin
			episode_left = $urandom_range(40, 8);
			growing = ($urandom_range(1) != 0);
			foreach (value_pool[i]) begin
				case ($urandom_range(9))
					0:       value_pool[i] = VAL_MAX;
					1:       value_pool[i] = VAL_MIN;
					default: value_pool[i] = $urandom;
				endcase
			end
		end
		episode_left--;
		append_pct = growing ? 60 : 12;
		if ($urandom_range(99) < append_pct) begin
			f = FN_APPEND;
		end else begin
			roll = $urandom_range(99);
			if (roll < 16)
				f = FN_POP_HEAD;
			else if (roll < 32)
				f = FN_POP_TAIL;
			else if (roll < 52)
				f = FN_REMOVE_VAL;
			else if (roll < 72)
				f = FN_REMOVE_POS;
			else if (roll < 96)
				f = FN_SEARCH;
			else if (roll < 98)
				f = FN_SPARE_A;
			else
				f = FN_SPARE_B;
		end
		// occasional fully random value: mostly a miss, and toggles every bit
		if ($urandom_range(9) < 8)
			v = value_pool[$urandom_range(POOL_N - 1)];
		else
			v = $urandom;
		offer_request(f, v, POS_W'($urandom_range(16)));
	endtask

	initial begin
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.data       = '0;
		sender_idle_pct   = 20;
		receiver_idle_pct = 60;
		holds_asked       = 0;
		episode_left      = 0;
		growing           = 1'b1;

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// --- directed part ---
		// head pop, search and position removal on an empty list
		offer_request(FN_POP_HEAD, VAL_MAX, 0);
		offer_request(FN_SEARCH, VAL_MIN, 0);
		offer_request(FN_REMOVE_POS, -1, 16);
		// fill to capacity: extremes, zero, a duplicated value, then random words
		offer_request(FN_APPEND, VAL_MAX, 0);
		offer_request(FN_APPEND, VAL_MIN, 31);
		offer_request(FN_APPEND, -1, 0);
		offer_request(FN_APPEND, 0, 0);
		offer_request(FN_APPEND, 5, 0);
		offer_request(FN_APPEND, 1, 0);
		offer_request(FN_APPEND, 5, 0);
		for (int i = 0; i < CAPACITY - 7; i++)
			offer_request(FN_APPEND, $urandom, 0);
		// append to a full list is rejected
		offer_request(FN_APPEND, 77, 0);
		// search hits the first of the two duplicates; a miss leaves the list alone
		offer_request(FN_SEARCH, 5, 0);
		offer_request(FN_SEARCH, 32'sh1234_5678, 0);
		// value removal from the middle, position zero as head, a position past
		// the end, then the exact tail by position and by pop
		offer_request(FN_REMOVE_VAL, VAL_MIN, 0);
		offer_request(FN_REMOVE_POS, 0, 0);
		offer_request(FN_REMOVE_POS, 0, 15);
		offer_request(FN_REMOVE_POS, 0, 14);
		offer_request(FN_POP_TAIL, 0, 0);
		offer_request(FN_SPARE_A, VAL_MAX, 16);

		// --- random part, three throttling phases ---
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					sender_idle_pct   = 20;
					receiver_idle_pct = 60;
				end
				1: begin
					sender_idle_pct   = 60;
					receiver_idle_pct = 20;
				end
				default: begin
					sender_idle_pct   = 0;
					receiver_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < RAND_PER_PHASE; n++) begin
				// with no idling the sender offers every cycle, so the block backs up fast
				if (phase == 2 && n == 100)
					holds_asked++;
				issue_random_request();
			end
		end
		req_ch.valid <= 1'b0;

		// drain: every owed response back, then a quiet window for strays
		wait (pending_rsp == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("checked %0d list transactions, %0d of them rejected (empty, not found or full),",
			rsp_checked, rsp_rejected);
		$display("across three idle mixes on both channels and one %0d-cycle response stall",
			HOLD_CYCLES);
		if (fail_total == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches", fail_total);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
